FILE: hw/rtl/rsenc_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rsenc_pkg
// Shared types, register indexes and GF(256) arithmetic for the Reed-Solomon
// systematic encoder.
// -----------------------------------------------------------------------------
package rsenc_pkg;

   // Configuration register indexes
   localparam logic CSR_PARITY_COUNT = 1'b0;
   localparam logic CSR_ROOT_STEP    = 1'b1;

   localparam logic [4:0] PARITY_COUNT_RESET = 5'd4;
   localparam logic [7:0] ROOT_STEP_RESET    = 8'd11;

   // x^8 = x^4 + x^3 + x + 1 for the field polynomial 0x11b
   localparam logic [7:0] GF_REDUCE = 8'h1b;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GEN,
      S_FOLD,
      S_PAR
   } state_type;

   typedef struct packed {
      logic gen_start;   // clear generator and remainder, power to one
      logic gen_step;    // one generator round
      logic hold_load;   // capture the input byte
      logic fold;        // one LFSR step
      logic fold_live;   // fold the byte on the input bus instead of the held one
      logic par_shift;   // advance the remainder toward the output
      logic out_load;    // load the output register
      logic out_parity;  // loaded byte is parity
      logic out_last;    // loaded byte closes the codeword
   } cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a byte this cycle
   } status_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      acc = 8'h00;
      x   = a;
      y   = b;
      for (int k = 0; k < 8; k++) begin
         if (y[0]) acc = acc ^ x;
         y = {1'b0, y[7:1]};
         x = {x[6:0], 1'b0} ^ (x[7] ? GF_REDUCE : 8'h00);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rs_systematic_encoder_gf256.sv
// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x11b. Message
// bytes enter on req_*, are echoed unchanged on rsp_* (tuser low) and are folded
// into an LFSR remainder; after the byte with req_tlast the P remainder bytes
// follow (tuser high), highest order first, the final one with rsp_tlast. P is
// parity_count (register 0) clamped to 1..MAX_PARITY, and the generator roots
// are successive powers of root_step (register 1), starting at the zeroth.
// The first byte of a message is folded only after the generator polynomial
// is built, one root per cycle by MAX_PARITY parallel GF multipliers. Every
// later byte is folded as it is accepted while the output side keeps up,
// because the LFSR update is a single parallel step. The last byte is followed
// by the P parity bytes, during which no byte is taken.
// An output register decouples the two sides, so a byte is accepted while the
// previous result still waits for rsp_tready. Write configuration only while
// the block is idle between messages.
`default_nettype none
// -----------------------------------------------------------------------------
// rs_systematic_encoder_gf256
// Top level: controller and datapath of the streaming RS(n, n-P) encoder.
// -----------------------------------------------------------------------------
module rs_systematic_encoder_gf256
   import rsenc_pkg::*;
#(
   parameter int MAX_PARITY = 16   // remainder and generator depth, 1..63
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Message bytes
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] data_byte
   input  wire logic       req_tlast,    // last_of_message
   // Codeword bytes
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,    // [7:0] out_byte
   output      logic       rsp_tuser,    // [0] is_parity
   output      logic       rsp_tlast,    // last
   // Register writes: index 0 parity_count (data[4:0]), index 1 root_step
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_data
);

   // Lane index width; holds 0 .. MAX_PARITY-1
   localparam int CW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

   cmd_type       cmd;
   status_type    stat;
   logic [7:0]    root_step;
   logic [CW-1:0] p_last;

   // Sequence derivation, folding and parity transfers
   rsenc_ctrl #(
      .MAX_PARITY (MAX_PARITY),
      .CW         (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .stat       (stat),
      .cmd        (cmd),
      .root_step  (root_step),
      .p_last     (p_last)
   );

   // Hold generator, remainder and the output register
   rsenc_dp #(
      .MAX_PARITY (MAX_PARITY),
      .CW         (CW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .root_step  (root_step),
      .p_last     (p_last),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/rsenc_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rsenc_dp
// Datapath: generator lanes, LFSR remainder lanes and the output register.
// -----------------------------------------------------------------------------
module rsenc_dp
   import rsenc_pkg::*;
#(
   parameter int MAX_PARITY = 16,
   parameter int CW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output      status_type    stat,
   input  wire logic [7:0]    root_step,
   input  wire logic [CW-1:0] p_last,
   input  wire logic [7:0]    req_tdata,
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   output      logic [7:0]    rsp_tdata,
   output      logic          rsp_tuser,
   output      logic          rsp_tlast
);

   localparam int VW = 8 * MAX_PARITY;

   logic [VW-1:0] gen_ff, gen_in;
   logic [VW-1:0] par_ff, par_in;
   logic [7:0]    power_ff, power_in;
   logic [7:0]    hold_ff, hold_in;
   logic [7:0]    out_data_ff, out_data_in;
   logic          out_user_ff, out_user_in;
   logic          out_last_ff, out_last_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    data_sel;
   logic [7:0]    fb;

   assign data_sel = cmd.fold_live ? req_tdata : hold_ff;
   assign fb       = data_sel ^ par_ff[7:0];

   for (genvar i = 0; i < MAX_PARITY; i++) begin : g_lane
      localparam logic [CW-1:0] LANE = CW'(i);
      logic [7:0] g_cur, p_cur, prev_g, upper_p, prod, p_fold;

      assign g_cur = gen_ff[8*i +: 8];
      assign p_cur = par_ff[8*i +: 8];

      // Coefficient of the next higher power; the leading one is implicit
      if (i == 0) begin : g_first
         assign prev_g = 8'h01;
      end else begin : g_rest
         assign prev_g = gen_ff[8*(i-1) +: 8];
      end

      if (i < MAX_PARITY - 1) begin : g_up
         assign upper_p = par_ff[8*(i+1) +: 8];
      end else begin : g_top
         assign upper_p = 8'h00;
      end

      assign prod   = gf_mul(g_cur, fb);
      assign p_fold = (LANE == p_last) ? prod : (upper_p ^ prod);

      assign gen_in[8*i +: 8] = cmd.gen_start ? 8'h00 :
                                cmd.gen_step  ? (g_cur ^ gf_mul(prev_g, power_ff)) : g_cur;

      assign par_in[8*i +: 8] = cmd.gen_start ? 8'h00 :
                                cmd.fold      ? ((LANE <= p_last) ? p_fold : p_cur) :
                                cmd.par_shift ? upper_p : p_cur;
   end

   always_comb begin
      power_in = power_ff;
      if (cmd.gen_start) begin
         power_in = 8'h01;
      end else if (cmd.gen_step) begin
         power_in = gf_mul(power_ff, root_step);
      end
   end

   assign hold_in = cmd.hold_load ? req_tdata : hold_ff;

   always_comb begin
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (cmd.out_load) begin
         out_data_in  = cmd.out_parity ? par_ff[7:0] : data_sel;
         out_user_in  = cmd.out_parity;
         out_last_in  = cmd.out_last;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff      <= gen_in;
      par_ff      <= par_in;
      power_ff    <= power_in;
      hold_ff     <= hold_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign stat.out_free = ~out_valid_ff | rsp_tready;
   assign rsp_tvalid    = out_valid_ff;
   assign rsp_tdata     = out_data_ff;
   assign rsp_tuser     = out_user_ff;
   assign rsp_tlast     = out_last_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/rsenc_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rsenc_ctrl
// Controller: configuration registers, parity count clamp and the sequencer
// for generator derivation, LFSR folding and parity emission.
// -----------------------------------------------------------------------------
module rsenc_ctrl
   import rsenc_pkg::*;
#(
   parameter int MAX_PARITY = 16,
   parameter int CW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire logic          req_tlast,
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic          csr_index,
   input  wire logic [7:0]    csr_data,
   input  wire status_type    stat,
   output      cmd_type       cmd,
   output      logic [7:0]    root_step,
   output      logic [CW-1:0] p_last
);

   localparam logic [6:0] MAX_W = 7'(MAX_PARITY);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          in_msg_ff, in_msg_in;
   logic          last_ff, last_in;
   logic [4:0]    pcount_ff, pcount_in;
   logic [7:0]    root_ff, root_in;
   logic [6:0]    pc_wide;
   logic [6:0]    pl_wide;

   assign csr_ready = 1'b1;

   always_comb begin
      pcount_in = pcount_ff;
      root_in   = root_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PARITY_COUNT: pcount_in = csr_data[4:0];
            CSR_ROOT_STEP:    root_in   = csr_data;
            default:          ;
         endcase
      end
   end

   // Clamp parity count to 1..MAX_PARITY and express it as the top lane index
   assign pc_wide = {2'b00, pcount_ff};
   always_comb begin
      if (pc_wide == 7'd0) begin
         pl_wide = 7'd0;
      end else if (pc_wide > MAX_W) begin
         pl_wide = MAX_W - 7'd1;
      end else begin
         pl_wide = pc_wide - 7'd1;
      end
   end
   assign p_last    = pl_wide[CW-1:0];
   assign root_step = root_ff;

   // Next state
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      in_msg_in = in_msg_ff;
      last_in   = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (!in_msg_ff) begin
                  in_msg_in = 1'b1;
                  last_in   = req_tlast;
                  cnt_in    = '0;
                  state_in  = S_GEN;
               end else if (stat.out_free) begin
                  if (req_tlast) begin
                     in_msg_in = 1'b0;
                     cnt_in    = '0;
                     state_in  = S_PAR;
                  end
               end else begin
                  last_in  = req_tlast;
                  state_in = S_FOLD;
               end
            end
         end
         S_GEN: begin
            if (cnt_ff == p_last) begin
               state_in = S_FOLD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_FOLD: begin
            if (stat.out_free) begin
               if (last_ff) begin
                  in_msg_in = 1'b0;
                  cnt_in    = '0;
                  state_in  = S_PAR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAR: begin
            if (stat.out_free) begin
               if (cnt_ff == p_last) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!in_msg_ff) begin
                  cmd.gen_start = 1'b1;
                  cmd.hold_load = 1'b1;
               end else if (stat.out_free) begin
                  cmd.fold      = 1'b1;
                  cmd.fold_live = 1'b1;
                  cmd.out_load  = 1'b1;
               end else begin
                  cmd.hold_load = 1'b1;
               end
            end
         end
         S_GEN: begin
            cmd.gen_step = 1'b1;
         end
         S_FOLD: begin
            if (stat.out_free) begin
               cmd.fold     = 1'b1;
               cmd.out_load = 1'b1;
            end
         end
         S_PAR: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_parity = 1'b1;
               cmd.out_last   = (cnt_ff == p_last);
               cmd.par_shift  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         in_msg_ff <= 1'b0;
         last_ff   <= 1'b0;
         pcount_ff <= PARITY_COUNT_RESET;
         root_ff   <= ROOT_STEP_RESET;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         in_msg_ff <= in_msg_in;
         last_ff   <= last_in;
         pcount_ff <= pcount_in;
         root_ff   <= root_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/rsenc_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rsenc_checker
// Port-level checks for the RS encoder, bound to the top level.
// -----------------------------------------------------------------------------
module rsenc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   // The codeword closes on a parity byte, never on an echoed message byte
   a_last_is_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tlast || rsp_tuser))
      else $error("codeword end marked on a message byte");

   // No message byte is taken while parity of the current codeword is pending
   a_no_accept_mid_parity: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && !rsp_tlast) |-> !req_tready)
      else $error("input taken during parity output");

   // Reset leaves no transfer pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled output changed");

endmodule

bind rs_systematic_encoder_gf256 rsenc_checker u_rsenc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
